// ===== sv/vcsp_pkg.sv =====
// Package for the command stream parser: opcodes, action codes, parse
// phases and the queue entry passed from the front end to the back end.
// No dependencies.
package vcsp_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int TARGET_W        = 32;
    localparam int WAIT_W          = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SONG_END     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] START_OFFSET_RST = 32'd64;

    // Opcodes
    localparam logic [7:0] OP_SKIP1_A   = 8'h4F;
    localparam logic [7:0] OP_SKIP1_B   = 8'h50;
    localparam logic [7:0] OP_SKIP2_LO  = 8'h51;
    localparam logic [7:0] OP_SKIP2_HI  = 8'h5D;
    localparam logic [7:0] OP_FM0_A     = 8'h5A;
    localparam logic [7:0] OP_FM0_B     = 8'h5B;
    localparam logic [7:0] OP_FM0_C     = 8'h5E;
    localparam logic [7:0] OP_FM1       = 8'h5F;
    localparam logic [7:0] OP_WAIT16    = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
    localparam logic [7:0] OP_LOOP      = 8'h66;
    localparam logic [7:0] OP_BLOCK     = 8'h67;
    localparam logic [7:0] OP_WAITN_LO  = 8'h70;
    localparam logic [7:0] OP_WAITN_HI  = 8'h8F;
    localparam logic [7:0] OP_SAA       = 8'hBD;
    localparam logic [7:0] OP_SKIP4     = 8'hE0;

    localparam logic [WAIT_W-1:0] WAIT_NTSC_TICKS = 16'd735;
    localparam logic [WAIT_W-1:0] WAIT_PAL_TICKS  = 16'd882;

    localparam logic [31:0] SKIP_ONE      = 32'd1;
    localparam logic [31:0] SKIP_TWO      = 32'd2;
    localparam logic [31:0] SKIP_FOUR     = 32'd4;
    localparam logic [31:0] BLK_HDR_BYTES = 32'd2;
    localparam logic [7:0]  BLK_SIZE_BYTES = 8'd4;

    typedef enum logic [1:0] {
        ACT_FM   = 2'd0,
        ACT_SAA  = 2'd1,
        ACT_WAIT = 2'd2,
        ACT_SEEK = 2'd3
    } action_kind_t;

    typedef enum logic [5:0] {
        PH_OPCODE  = 6'b000001,
        PH_ARG1    = 6'b000010,
        PH_ARG2    = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_BLKHDR  = 6'b010000,
        PH_BLKSIZE = 6'b100000
    } phase_t;

    // What a command produces ahead of an optional seek
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_WAIT = 2'd1,
        CMD_FM   = 2'd2,
        CMD_SAA  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                fm_port;
        logic                chip;
        logic [7:0]          data0;
        logic [7:0]          data1;
        logic [WAIT_W-1:0]   wait_count;
        logic                seek;
        logic [TARGET_W-1:0] target;
    } cmd_t;

endpackage

// ===== sv/vcsp_if.sv =====
// Channel interfaces of the command stream parser: byte input and
// action output. Depends on nothing.
interface vcsp_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface vcsp_action_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action_kind;
    logic [1:0]  bus_address;
    logic        chip_select;
    logic [7:0]  bus_data;
    logic [15:0] wait_count;
    logic [31:0] seek_target;
    logic        last_action;

    modport source (output valid, output action_kind, output bus_address,
                    output chip_select, output bus_data, output wait_count,
                    output seek_target, output last_action, input ready);
    modport sink   (input valid, input action_kind, input bus_address,
                    input chip_select, input bus_data, input wait_count,
                    input seek_target, input last_action, output ready);
endinterface

// ===== sv/vcsp_front.sv =====
// Front end: accepts stream beats, tracks position and parse phase,
// and pushes one command entry per byte that yields actions.
// Depends on vcsp_pkg and vcsp_if.
module vcsp_front #(
    parameter int OFFSET_BITS = vcsp_pkg::OFFSET_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [vcsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vcsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    vcsp_stream_if.sink                      stream,
    output logic                             push,
    output vcsp_pkg::cmd_t                   push_data,
    input  logic                             full
);
    import vcsp_pkg::*;

    logic [OFFSET_BITS-1:0] start_reg, loop_reg, end_reg;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, pos_inc, pos_land;
    phase_t                 phase_reg, phase_next;
    logic [7:0]             opcode_reg, opcode_next;
    logic [7:0]             arg_reg, arg_next, arg_inc;
    logic [31:0]            skip_reg, skip_next, skip_dec, skip_or;
    logic                   accept, done, loop_hit, seek;
    cmd_t                   cmd;
    logic [7:0]             b;

    // no beat is taken while a config write updates the parser state
    assign stream.ready = !full && !cfg_write;
    assign accept       = stream.valid && !full && !cfg_write;
    assign b            = stream.stream_byte;

    assign pos_inc  = pos_reg + OFFSET_BITS'(1);
    assign skip_dec = (skip_reg != 32'd0) ? skip_reg - 32'd1 : skip_reg;
    assign skip_or  = skip_reg | ({24'd0, b} << {arg_reg[1:0], 3'b000});
    assign arg_inc  = arg_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        arg_next    = arg_reg;
        skip_next   = skip_reg;
        done        = 1'b0;
        loop_hit    = 1'b0;
        cmd         = '0;
        cmd.kind    = CMD_NONE;

        case (phase_reg)
            PH_ARG1:
            begin
                arg_next   = b;
                phase_next = PH_ARG2;
            end
            PH_ARG2:
            begin
                done = 1'b1;
                if (opcode_reg == OP_WAIT16)
                begin
                    cmd.kind       = CMD_WAIT;
                    cmd.wait_count = {b, arg_reg};
                end
                else if (opcode_reg == OP_SAA)
                begin
                    cmd.kind  = CMD_SAA;
                    cmd.chip  = arg_reg[7];
                    cmd.data0 = arg_reg;
                    cmd.data1 = b;
                end
                else
                begin
                    cmd.kind    = CMD_FM;
                    cmd.fm_port = (opcode_reg == OP_FM1);
                    cmd.data0   = arg_reg;
                    cmd.data1   = b;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                done      = (skip_dec == 32'd0);
            end
            PH_BLKHDR:
            begin
                skip_next = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    phase_next = PH_BLKSIZE;
                    arg_next   = 8'd0;
                end
            end
            PH_BLKSIZE:
            begin
                skip_next = skip_or;
                arg_next  = arg_inc;
                if (arg_inc >= BLK_SIZE_BYTES)
                begin
                    if (skip_or == 32'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_SKIP;
                end
            end
            PH_OPCODE:
            begin
                opcode_next = b;
                case (b) inside
                    OP_SKIP1_A, OP_SKIP1_B:
                    begin
                        skip_next  = SKIP_ONE;
                        phase_next = PH_SKIP;
                    end
                    OP_FM0_A, OP_FM0_B, OP_FM0_C, OP_FM1, OP_WAIT16, OP_SAA:
                        phase_next = PH_ARG1;
                    [OP_SKIP2_LO:OP_SKIP2_HI]:
                    begin
                        skip_next  = SKIP_TWO;
                        phase_next = PH_SKIP;
                    end
                    OP_WAIT_NTSC:
                    begin
                        cmd.kind       = CMD_WAIT;
                        cmd.wait_count = WAIT_NTSC_TICKS;
                        done           = 1'b1;
                    end
                    OP_WAIT_PAL:
                    begin
                        cmd.kind       = CMD_WAIT;
                        cmd.wait_count = WAIT_PAL_TICKS;
                        done           = 1'b1;
                    end
                    [OP_WAITN_LO:OP_WAITN_HI]:
                    begin
                        cmd.kind       = CMD_WAIT;
                        cmd.wait_count = {12'd0, b[3:0]};
                        done           = 1'b1;
                    end
                    OP_LOOP:
                    begin
                        loop_hit = 1'b1;
                        done     = 1'b1;
                    end
                    OP_BLOCK:
                    begin
                        skip_next  = BLK_HDR_BYTES;
                        phase_next = PH_BLKHDR;
                    end
                    OP_SKIP4:
                    begin
                        skip_next  = SKIP_FOUR;
                        phase_next = PH_SKIP;
                    end
                    default:
                        done = 1'b1;
                endcase
            end
            default:
                phase_next = PH_OPCODE;
        endcase

        // Command end: loop jump, then song end check on the landing spot
        pos_land = loop_hit ? loop_reg : pos_inc;
        pos_next = pos_inc;
        seek     = 1'b0;
        if (done)
        begin
            phase_next = PH_OPCODE;
            skip_next  = 32'd0;
            pos_next   = pos_land;
            seek       = loop_hit;
            if (pos_land == end_reg)
            begin
                pos_next = start_reg;
                seek     = 1'b1;
            end
        end
        cmd.seek   = seek;
        cmd.target = TARGET_W'(pos_next);
    end

    assign push      = accept && ((cmd.kind != CMD_NONE) || seek);
    assign push_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_OFFSET_RST[OFFSET_BITS-1:0];
            loop_reg   <= '0;
            end_reg    <= '0;
            pos_reg    <= START_OFFSET_RST[OFFSET_BITS-1:0];
            phase_reg  <= PH_OPCODE;
            opcode_reg <= '0;
            arg_reg    <= '0;
            skip_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_OFFSET:
                begin
                    start_reg <= cfg_data[OFFSET_BITS-1:0];
                    pos_reg   <= cfg_data[OFFSET_BITS-1:0];
                    phase_reg <= PH_OPCODE;
                    skip_reg  <= '0;
                end
                CFG_LOOP_OFFSET: loop_reg <= cfg_data[OFFSET_BITS-1:0];
                CFG_SONG_END:    end_reg  <= cfg_data[OFFSET_BITS-1:0];
                default:         ;
            endcase
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            arg_reg    <= arg_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

// ===== sv/vcsp_queue.sv =====
// Command queue between parser front end and action back end.
// Register storage, one write and one read per cycle. Depends on vcsp_pkg.
module vcsp_queue #(
    parameter int DEPTH = vcsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vcsp_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output vcsp_pkg::cmd_t  head_data
);
    import vcsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("queue pop while empty");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");
`endif

endmodule

// ===== sv/vcsp_back.sv =====
// Back end: expands each queued command into its action beats and
// drives them through an output register. Depends on vcsp_pkg, vcsp_if.
module vcsp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  vcsp_pkg::cmd_t  head_data,
    output logic            pop,
    vcsp_action_if.source   action
);
    import vcsp_pkg::*;

    logic [1:0]   beat_reg;
    logic [1:0]   n_main, n_total;
    logic         load, beat_last;
    action_kind_t kind_b;
    logic [1:0]   addr_b;
    logic         chip_b;
    logic [7:0]   data_b;
    logic [15:0]  wait_b;
    logic [31:0]  target_b;

    logic         valid_reg;
    action_kind_t kind_reg;
    logic [1:0]   addr_reg;
    logic         chip_reg;
    logic [7:0]   data_reg;
    logic [15:0]  wait_reg;
    logic [31:0]  target_reg;
    logic         last_reg;

    always_comb
    begin
        case (head_data.kind)
            CMD_FM, CMD_SAA: n_main = 2'd2;
            CMD_WAIT:        n_main = 2'd1;
            default:         n_main = 2'd0;
        endcase
        n_total   = n_main + {1'b0, head_data.seek};
        beat_last = (beat_reg == n_total - 2'd1);

        kind_b   = ACT_SEEK;
        addr_b   = 2'd0;
        chip_b   = 1'b0;
        data_b   = 8'd0;
        wait_b   = 16'd0;
        target_b = head_data.target;
        if (beat_reg < n_main)
        begin
            target_b = 32'd0;
            case (head_data.kind)
                CMD_FM:
                begin
                    kind_b = ACT_FM;
                    addr_b = {head_data.fm_port, beat_reg[0]};
                    data_b = beat_reg[0] ? head_data.data1 : head_data.data0;
                end
                CMD_SAA:
                begin
                    // register select first, then data
                    kind_b = ACT_SAA;
                    addr_b = {1'b0, ~beat_reg[0]};
                    chip_b = head_data.chip;
                    data_b = beat_reg[0] ? head_data.data1 : head_data.data0;
                end
                default:
                begin
                    kind_b = ACT_WAIT;
                    wait_b = head_data.wait_count;
                end
            endcase
        end
    end

    assign load = head_valid && (!valid_reg || action.ready);
    assign pop  = load && beat_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                beat_reg  <= beat_last ? 2'd0 : beat_reg + 2'd1;
            end
            else if (action.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= kind_b;
            addr_reg   <= addr_b;
            chip_reg   <= chip_b;
            data_reg   <= data_b;
            wait_reg   <= wait_b;
            target_reg <= target_b;
            last_reg   <= beat_last;
        end
    end

    assign action.valid       = valid_reg;
    assign action.action_kind = kind_reg;
    assign action.bus_address = addr_reg;
    assign action.chip_select = chip_reg;
    assign action.bus_data    = data_reg;
    assign action.wait_count  = wait_reg;
    assign action.seek_target = target_reg;
    assign action.last_action = last_reg;

`ifndef NO_ASSERTIONS
    a_beat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (beat_reg < n_total))
        else $error("beat index past end of command");
    a_pop_resets_beat: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (beat_reg == 2'd0))
        else $error("beat index not cleared after pop");
    a_seek_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == ACT_SEEK) |-> last_reg)
        else $error("seek action not flagged last");
`endif

endmodule

// ===== sv/vgm_command_stream_parser.sv =====
// Path: a byte accepted on the stream port is written into the command
// queue and its first action is then loaded into the output register, when
// nothing is queued ahead of it.
// Throughput: one stream beat per cycle unless the queue is full or a config
// write is on; one action beat per cycle while action.ready holds, and the
// queue (QUEUE_DEPTH entries) absorbs bytes with two or three actions.
// Reset (rst_n, async low): position = 64, parser expects an opcode, queue
// and output empty; writing start_offset restarts the parser there.
//
// Top level of the command stream parser. Depends on vcsp_pkg, vcsp_if,
// vcsp_front, vcsp_queue, vcsp_back.
module vgm_command_stream_parser #(
    parameter int OFFSET_BITS = vcsp_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = vcsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [vcsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vcsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    vcsp_stream_if.sink                      stream,
    vcsp_action_if.source                    action
);
    import vcsp_pkg::*;

    // Front end to queue
    logic push;
    cmd_t push_data;
    logic full;

    // Queue to back end
    logic pop;
    logic head_valid;
    cmd_t head_data;

    // Front end: one byte per beat, phase machine and position tracking.
    // Stalls when the queue is full or during a config write.
    vcsp_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Decouples byte parsing from action delivery
    vcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Back end: writes, waits and seeks, one action beat per cycle while ready
    vcsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .action     (action)
    );

endmodule
